[rtl/rwl_pkg.sv]
package rwl_pkg;

    localparam int unsigned DEF_QUEUE_DEPTH = 16;
    localparam int unsigned DEF_MAX_READERS = 255;
    localparam int unsigned RESULT_LIMIT    = 16;
    localparam int unsigned WAKE_W          = $clog2(RESULT_LIMIT + 1);

    localparam int unsigned REQ_W    = 2;
    localparam int unsigned PID_W    = 16;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned ENTRY_W  = PID_W + 1;

    typedef logic [REQ_W-1:0]    t_req;
    typedef logic [PID_W-1:0]    t_pid;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_req REQ_OPEN_READ   = 2'd0;
    localparam t_req REQ_OPEN_WRITE  = 2'd1;
    localparam t_req REQ_CLOSE_READ  = 2'd2;
    localparam t_req REQ_CLOSE_WRITE = 2'd3;

    localparam t_status ST_GRANTED = 3'd0;
    localparam t_status ST_QUEUED  = 3'd1;
    localparam t_status ST_FULL    = 3'd2;
    localparam t_status ST_RELEASE = 3'd3;
    localparam t_status ST_WOKEN   = 3'd4;
    localparam t_status ST_BAD     = 3'd5;
    localparam t_status ST_LIMIT   = 3'd6;

    typedef struct packed {
        logic accept;
        logic eval;
        logic take;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic walk;
        logic take;
        logic take_wr;
        logic out_free;
        logic pend_valid;
    } t_sts;

endpackage

[rtl/rwl_if.sv]
interface rwl_req_if;
    import rwl_pkg::*;
    logic valid;
    logic ready;
    t_req req_type;
    t_pid pid;
    modport source (output valid, output req_type, output pid, input ready);
    modport sink   (input valid, input req_type, input pid, output ready);
endinterface

interface rwl_res_if;
    import rwl_pkg::*;
    logic    valid;
    logic    ready;
    t_status status;
    t_pid    grant_pid;
    logic    grant_is_write;
    logic    last;
    modport source (output valid, output status, output grant_pid,
                    output grant_is_write, output last, input ready);
    modport sink   (input valid, input status, input grant_pid,
                    input grant_is_write, input last, output ready);
endinterface

[rtl/rwl_ram.sv]
module rwl_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/rwl_ctrl.sv]
module rwl_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rwl_pkg::t_sts i_sts,
    output rwl_pkg::t_cmd o_cmd
);
    import rwl_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_RDQ  = 3'd2;
    localparam logic [2:0] S_EXAM = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_sts.out_free) begin
                    o_cmd.eval = 1'b1;
                    n_state    = i_sts.walk ? S_RDQ : S_IDLE;
                end
            end
            S_RDQ: begin
                n_state = S_EXAM;
            end
            S_EXAM: begin
                if (i_sts.take) begin
                    if (!i_sts.pend_valid || i_sts.out_free) begin
                        o_cmd.take = 1'b1;
                        n_state    = i_sts.take_wr ? S_FIN : S_RDQ;
                    end
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/rwl_dpath.sv]
module rwl_dpath #(
    parameter int unsigned QUEUE_DEPTH = rwl_pkg::DEF_QUEUE_DEPTH,
    parameter int unsigned MAX_READERS = rwl_pkg::DEF_MAX_READERS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rwl_pkg::t_cmd    i_cmd,
    output rwl_pkg::t_sts    o_sts,
    input  rwl_pkg::t_req    i_req_type,
    input  rwl_pkg::t_pid    i_pid,
    output logic             o_valid,
    input  logic             i_ready,
    output rwl_pkg::t_status o_status,
    output rwl_pkg::t_pid    o_grant_pid,
    output logic             o_grant_is_write,
    output logic             o_last
);
    import rwl_pkg::*;

    localparam int unsigned QW  = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned RCW = $clog2(MAX_READERS + 1);

    t_req               r_req;
    t_pid               r_pid;
    logic               r_wh,     n_wh;
    logic [RCW-1:0]     r_rc,     n_rc;
    logic [QW-1:0]      r_head,   n_head;
    logic [QW-1:0]      r_tail,   n_tail;
    logic [CW-1:0]      r_cnt,    n_cnt;
    logic [WAKE_W-1:0]  r_nwk,    n_nwk;
    logic               r_pend_v, n_pend_v;
    t_pid               r_pend_pid, n_pend_pid;
    logic               r_pend_w,   n_pend_w;
    logic               r_ovalid, n_ovalid;
    t_status            r_ost,    n_ost;
    t_pid               r_opid,   n_opid;
    logic               r_ow,     n_ow;
    logic               r_olast,  n_olast;

    logic               ram_we;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    logic               out_free;
    logic               q_full;
    logic               e_mode;
    t_pid               e_pid;
    logic               take_ok;
    logic               eval_walk;

    rwl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tail),
        .i_wdata (ram_wdata),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    assign out_free = !r_ovalid || i_ready;
    assign q_full   = (r_cnt == CW'(QUEUE_DEPTH));
    assign e_mode   = ram_rdata[PID_W];
    assign e_pid    = ram_rdata[PID_W-1:0];

    always_comb begin
        take_ok = 1'b0;
        if (r_cnt != '0 && r_nwk < WAKE_W'(RESULT_LIMIT)) begin
            if (e_mode) begin
                take_ok = (r_nwk == '0) && !r_wh && (r_rc == '0);
            end else begin
                take_ok = !r_wh && (r_rc < RCW'(MAX_READERS));
            end
        end
    end

    always_comb begin
        eval_walk = 1'b0;
        case (r_req)
            REQ_CLOSE_READ:  eval_walk = (r_rc == RCW'(1)) && !r_wh;
            REQ_CLOSE_WRITE: eval_walk = r_wh && (r_rc == '0);
            default:         eval_walk = 1'b0;
        endcase
    end

    always_comb begin
        n_wh       = r_wh;
        n_rc       = r_rc;
        n_head     = r_head;
        n_tail     = r_tail;
        n_cnt      = r_cnt;
        n_nwk      = r_nwk;
        n_pend_v   = r_pend_v;
        n_pend_pid = r_pend_pid;
        n_pend_w   = r_pend_w;
        n_ovalid   = r_ovalid && !i_ready;
        n_ost      = r_ost;
        n_opid     = r_opid;
        n_ow       = r_ow;
        n_olast    = r_olast;
        ram_we     = 1'b0;
        ram_wdata  = {r_req == REQ_OPEN_WRITE, r_pid};

        if (i_cmd.eval) begin
            n_nwk    = '0;
            n_pend_v = 1'b0;
            n_opid   = r_pid;
            n_ow     = 1'b0;
            n_olast  = 1'b1;
            n_ovalid = !eval_walk;
            case (r_req)
                REQ_OPEN_READ: begin
                    if (r_wh) begin
                        n_ost = q_full ? ST_FULL : ST_QUEUED;
                        ram_we = !q_full;
                    end else if (r_rc >= RCW'(MAX_READERS)) begin
                        n_ost = ST_LIMIT;
                    end else begin
                        n_rc  = r_rc + RCW'(1);
                        n_ost = ST_GRANTED;
                    end
                end
                REQ_OPEN_WRITE: begin
                    n_ow = 1'b1;
                    if (r_wh || r_rc != '0) begin
                        n_ost = q_full ? ST_FULL : ST_QUEUED;
                        ram_we = !q_full;
                    end else begin
                        n_wh  = 1'b1;
                        n_ost = ST_GRANTED;
                    end
                end
                REQ_CLOSE_READ: begin
                    if (r_rc == '0) begin
                        n_ost = ST_BAD;
                    end else begin
                        n_rc  = r_rc - RCW'(1);
                        n_ost = ST_RELEASE;
                    end
                end
                default: begin
                    if (!r_wh) begin
                        n_ost = ST_BAD;
                    end else begin
                        n_wh  = 1'b0;
                        n_ost = ST_RELEASE;
                    end
                end
            endcase
            if (ram_we) begin
                n_tail = (r_tail == QW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + QW'(1);
                n_cnt  = r_cnt + CW'(1);
            end
        end

        if (i_cmd.take) begin
            if (r_pend_v) begin
                n_ovalid = 1'b1;
                n_ost    = ST_WOKEN;
                n_opid   = r_pend_pid;
                n_ow     = r_pend_w;
                n_olast  = 1'b0;
            end
            n_pend_v   = 1'b1;
            n_pend_pid = e_pid;
            n_pend_w   = e_mode;
            n_head     = (r_head == QW'(QUEUE_DEPTH - 1)) ? '0 : r_head + QW'(1);
            n_cnt      = r_cnt - CW'(1);
            n_nwk      = r_nwk + WAKE_W'(1);
            if (e_mode) begin
                n_wh = 1'b1;
            end else begin
                n_rc = r_rc + RCW'(1);
            end
        end

        if (i_cmd.fin) begin
            n_ovalid = 1'b1;
            n_olast  = 1'b1;
            n_pend_v = 1'b0;
            if (r_pend_v) begin
                n_ost  = ST_WOKEN;
                n_opid = r_pend_pid;
                n_ow   = r_pend_w;
            end else begin
                n_ost  = ST_RELEASE;
                n_opid = r_pid;
                n_ow   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req <= i_req_type;
            r_pid <= i_pid;
        end
        r_nwk      <= n_nwk;
        r_pend_pid <= n_pend_pid;
        r_pend_w   <= n_pend_w;
        r_ost      <= n_ost;
        r_opid     <= n_opid;
        r_ow       <= n_ow;
        r_olast    <= n_olast;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wh     <= 1'b0;
            r_rc     <= '0;
            r_head   <= '0;
            r_tail   <= '0;
            r_cnt    <= '0;
            r_pend_v <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_wh     <= n_wh;
            r_rc     <= n_rc;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_cnt    <= n_cnt;
            r_pend_v <= n_pend_v;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_sts.walk       = eval_walk;
    assign o_sts.take       = take_ok;
    assign o_sts.take_wr    = e_mode;
    assign o_sts.out_free   = out_free;
    assign o_sts.pend_valid = r_pend_v;

    assign o_valid          = r_ovalid;
    assign o_status         = r_ost;
    assign o_grant_pid      = r_opid;
    assign o_grant_is_write = r_ow;
    assign o_last           = r_olast;

endmodule

[rtl/reader_writer_lock_arbiter_unit.sv]
// A request with no queue walk yields a single result, registered from its evaluation step.
// A release walk visits each queue entry it examines with a registered queue RAM read (RDQ)
// followed by an examination (EXAM); it ends after a woken writer or when no entry can be taken.
// Only one request is handled at a time: a new request is accepted only once the previous one,
// including its walk, has finished; output stalls hold the evaluation, the walk and the result.
// Reset (synchronous, active low) clears lock state, queue pointers and output valid, not the RAM.
module reader_writer_lock_arbiter_unit #(
    parameter int unsigned QUEUE_DEPTH = rwl_pkg::DEF_QUEUE_DEPTH,
    parameter int unsigned MAX_READERS = rwl_pkg::DEF_MAX_READERS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rwl_req_if.sink   i_req,
    rwl_res_if.source o_res
);
    import rwl_pkg::*;

    t_cmd cmd;
    t_sts sts;

    rwl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rwl_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MAX_READERS (MAX_READERS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_req_type       (i_req.req_type),
        .i_pid            (i_req.pid),
        .o_valid          (o_res.valid),
        .i_ready          (o_res.ready),
        .o_status         (o_res.status),
        .o_grant_pid      (o_res.grant_pid),
        .o_grant_is_write (o_res.grant_is_write),
        .o_last           (o_res.last)
    );

endmodule

[dv/reader_writer_lock_arbiter_unit_tb.sv]
module reader_writer_lock_arbiter_unit_tb;
    import rwl_pkg::*;

    localparam int unsigned QDEPTH      = DEF_QUEUE_DEPTH;
    localparam int unsigned READER_MAX  = DEF_MAX_READERS;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_WAIT  = 2 * RESULT_LIMIT + 8;

    typedef struct packed {
        t_status status;
        t_pid    pid;
        logic    wr;
        logic    last;
    } t_grant;

    typedef struct packed {
        logic wr;
        t_pid pid;
    } t_waiter;

    class grant_scoreboard;
        bit          writer_held;
        int unsigned reader_count;
        t_waiter     waiters[$];
        t_grant      due_grants[$];
        t_grant      burst[$];
        int unsigned mismatches;

        function t_grant mk(t_status st, t_pid p, logic wr);
            t_grant g;
            g.status = st;
            g.pid    = p;
            g.wr     = wr;
            g.last   = 1'b0;
            return g;
        endfunction

        function void park(t_pid p, logic wr);
            t_waiter w;
            if (waiters.size() >= QDEPTH) begin
                burst.push_back(mk(ST_FULL, p, wr));
            end else begin
                w.wr  = wr;
                w.pid = p;
                waiters.push_back(w);
                burst.push_back(mk(ST_QUEUED, p, wr));
            end
        endfunction

        function void wake_waiters(t_pid p);
            int unsigned n;
            n = 0;
            while (waiters.size() > 0 && n < RESULT_LIMIT) begin
                if (!waiters[0].wr) begin
                    if (writer_held || reader_count >= READER_MAX) break;
                    reader_count++;
                    burst.push_back(mk(ST_WOKEN, waiters[0].pid, 1'b0));
                    n++;
                    void'(waiters.pop_front());
                end else begin
                    if (n == 0 && !writer_held && reader_count == 0) begin
                        writer_held = 1'b1;
                        burst.push_back(mk(ST_WOKEN, waiters[0].pid, 1'b1));
                        n++;
                        void'(waiters.pop_front());
                    end
                    break;
                end
            end
            if (n == 0) burst.push_back(mk(ST_RELEASE, p, 1'b0));
        endfunction

        function void note_request(t_req r, t_pid p);
            burst.delete();
            case (r)
                REQ_OPEN_READ: begin
                    if (writer_held) begin
                        park(p, 1'b0);
                    end else if (reader_count >= READER_MAX) begin
                        burst.push_back(mk(ST_LIMIT, p, 1'b0));
                    end else begin
                        reader_count++;
                        burst.push_back(mk(ST_GRANTED, p, 1'b0));
                    end
                end
                REQ_OPEN_WRITE: begin
                    if (writer_held || reader_count > 0) begin
                        park(p, 1'b1);
                    end else begin
                        writer_held = 1'b1;
                        burst.push_back(mk(ST_GRANTED, p, 1'b1));
                    end
                end
                REQ_CLOSE_READ: begin
                    if (reader_count == 0) begin
                        burst.push_back(mk(ST_BAD, p, 1'b0));
                    end else begin
                        reader_count--;
                        if (reader_count == 0 && !writer_held) wake_waiters(p);
                        else burst.push_back(mk(ST_RELEASE, p, 1'b0));
                    end
                end
                default: begin
                    if (!writer_held) begin
                        burst.push_back(mk(ST_BAD, p, 1'b0));
                    end else begin
                        writer_held = 1'b0;
                        if (reader_count == 0) wake_waiters(p);
                        else burst.push_back(mk(ST_RELEASE, p, 1'b0));
                    end
                end
            endcase
            burst[burst.size() - 1].last = 1'b1;
            foreach (burst[i]) due_grants.push_back(burst[i]);
        endfunction

        function void report(string what, t_grant want, t_grant got);
            mismatches++;
            if (mismatches <= 10)
                $display("%s: expected st=%0d pid=%h wr=%b last=%b, got st=%0d pid=%h wr=%b last=%b",
                         what, want.status, want.pid, want.wr, want.last,
                         got.status, got.pid, got.wr, got.last);
        endfunction

        function void check_grant(t_grant got);
            t_grant want;
            if (due_grants.size() == 0) begin
                want = '0;
                report("unexpected transaction", want, got);
                return;
            end
            want = due_grants.pop_front();
            if (got.status !== want.status || got.pid !== want.pid ||
                got.wr !== want.wr || got.last !== want.last)
                report("mismatch", want, got);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   calm;
    int unsigned cycles;

    grant_scoreboard sb = new;

    rwl_req_if req_ch ();
    rwl_res_if res_ch ();

    reader_writer_lock_arbiter_unit #(
        .QUEUE_DEPTH (QDEPTH),
        .MAX_READERS (READER_MAX)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_res   (res_ch.source)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin : result_side
        t_grant seen;
        if (i_rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            seen.status = res_ch.status;
            seen.pid    = res_ch.grant_pid;
            seen.wr     = res_ch.grant_is_write;
            seen.last   = res_ch.last;
            sb.check_grant(seen);
        end
        res_ch.ready <= calm || ($urandom_range(99) >= 17);
    end

    function automatic t_pid rand_pid();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return t_pid'($urandom_range(16'hFFFF));
        endcase
    endfunction

    task automatic send_request(input t_req r, input t_pid p);
        int gap;
        gap = 0;
        if (!calm) while ($urandom_range(99) < 17) gap++;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= r;
        req_ch.pid      <= p;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        sb.note_request(r, p);
    endtask

    task automatic release_all();
        while (sb.reader_count > 0 || sb.writer_held) begin
            if (sb.writer_held) send_request(REQ_CLOSE_WRITE, rand_pid());
            else send_request(REQ_CLOSE_READ, rand_pid());
        end
    endtask

    task automatic run_mix(input int n);
        int   pick;
        int   fill_left;
        t_req r;
        fill_left = 0;
        for (int i = 0; i < n; i++) begin
            calm = (i >= n / 3 && i < n / 3 + 40);
            pick = $urandom_range(99);
            if (fill_left == 0 && sb.writer_held && pick < 6)
                fill_left = $urandom_range(12, 20);
            if (fill_left > 0) begin
                fill_left--;
                r = ($urandom_range(4) == 0) ? REQ_OPEN_WRITE : REQ_OPEN_READ;
            end else if (pick < 8) begin
                r = t_req'($urandom_range(3));
            end else if (pick < 30) begin
                r = REQ_OPEN_READ;
            end else if (pick < 47) begin
                r = REQ_OPEN_WRITE;
            end else if (pick < 77) begin
                r = (sb.reader_count > 0) ? REQ_CLOSE_READ : REQ_OPEN_READ;
            end else begin
                r = sb.writer_held ? REQ_CLOSE_WRITE : REQ_OPEN_WRITE;
            end
            send_request(r, rand_pid());
        end
        calm = 1'b0;
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= REQ_OPEN_READ;
        req_ch.pid      <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(REQ_CLOSE_READ,  16'h0000);
        send_request(REQ_CLOSE_WRITE, 16'hFFFF);
        send_request(REQ_OPEN_READ,   16'h0001);
        send_request(REQ_OPEN_WRITE,  16'h0002);
        send_request(REQ_CLOSE_READ,  16'h0001);
        send_request(REQ_OPEN_READ,   16'h8000);
        send_request(REQ_CLOSE_WRITE, 16'h0002);
        send_request(REQ_OPEN_WRITE,  16'h7FFF);
        send_request(REQ_OPEN_READ,   16'h00FF);
        send_request(REQ_CLOSE_READ,  16'hAAAA);
        send_request(REQ_CLOSE_READ,  16'h5555);
        release_all();
        send_request(REQ_CLOSE_READ,  16'hFFFF);

        run_mix(122);
        run_mix(122);

        req_ch.valid <= 1'b0;
        while (sb.due_grants.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.due_grants.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[reader_writer_lock_arbiter_unit.f]
rtl/rwl_pkg.sv
rtl/rwl_if.sv
rtl/rwl_ram.sv
rtl/rwl_ctrl.sv
rtl/rwl_dpath.sv
rtl/reader_writer_lock_arbiter_unit.sv
dv/reader_writer_lock_arbiter_unit_tb.sv
